// File: rtl/core/wbts_pkg.sv
// Shared constants, codes and helper functions of the wrapped bilinear texture sampler.
// No dependencies; the top level, wbts_axis, the checker and the testbench import this package.
package wbts_pkg;

	localparam int MaxWidthDef      = 256;
	localparam int MaxHeightDef     = 256;
	localparam int MaxChannelsDef   = 4;
	localparam int CoordFracBitsDef = 16;

	localparam int ExtentW = 9;
	localparam int CountW  = 3;
	localparam int PaddrW  = 4;

	localparam logic [1:0] RegWidth  = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;
	localparam logic [1:0] RegCount  = 2'd2;

	localparam logic [1:0] FuncWrite    = 2'd0;
	localparam logic [1:0] FuncRead     = 2'd1;
	localparam logic [1:0] FuncNearest  = 2'd2;
	localparam logic [1:0] FuncBilinear = 2'd3;

	// Zero reads as one; values above the limit saturate to the limit.
	function automatic logic [ExtentW-1:0] clamp_reg(input logic [ExtentW-1:0] v,
		input int unsigned maxv);
		logic [ExtentW-1:0] r;
		if (v == '0) begin
			r = ExtentW'(1);
		end else if (32'(v) > maxv) begin
			r = ExtentW'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Byte mask of the channels in use.
	function automatic logic [31:0] chan_mask(input logic [CountW-1:0] n);
		logic [31:0] m;
		case (n)
			3'd1:    m = 32'h0000_00FF;
			3'd2:    m = 32'h0000_FFFF;
			3'd3:    m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/core/wbts_if.sv
// Request and result channel interfaces of the texture sampler.
// Depends on nothing; the payload widths are fixed by the field definitions.
interface wbts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  pos_x;
	logic [7:0]  pos_y;
	logic [7:0]  write_ch0;
	logic [7:0]  write_ch1;
	logic [7:0]  write_ch2;
	logic [7:0]  write_ch3;
	logic [15:0] coord_u;
	logic [15:0] coord_v;

	modport source(output valid, func, pos_x, pos_y, write_ch0, write_ch1, write_ch2,
		write_ch3, coord_u, coord_v, input ready);
	modport sink(input valid, func, pos_x, pos_y, write_ch0, write_ch1, write_ch2,
		write_ch3, coord_u, coord_v, output ready);
endinterface

interface wbts_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_ch0;
	logic [7:0] out_ch1;
	logic [7:0] out_ch2;
	logic [7:0] out_ch3;
	logic       range_error;

	modport source(output valid, out_ch0, out_ch1, out_ch2, out_ch3, range_error,
		input ready);
	modport sink(input valid, out_ch0, out_ch1, out_ch2, out_ch3, range_error,
		output ready);
endinterface

// File: rtl/core/wrapped_bilinear_texture_sampler.sv
// Wrapped bilinear texture sampler, top level.
// Depends on wbts_pkg, wbts_if, wbts_ram and wbts_axis.
//
// Requests arrive on req (valid/ready) and carry one of four functions: write a pixel,
// read a pixel, take the nearest texel to a repeating (u,v) coordinate, or blend the
// four texels around (u,v) bilinearly with wrap at every edge. Every function but the
// write produces exactly one result on rsp. Image width, height and channel count are
// set through the APB port at byte addresses 0, 4 and 8; the user must set them only
// while the block is idle, which the block itself does not enforce. Texels live in one
// single-port memory of MAX_WIDTH*MAX_HEIGHT words; its contents are undefined after
// reset until written, so no clearing pass runs. A request is taken in the idle state,
// the axis state computes the texel indices and weights, then the memory port fetches
// one texel per cycle (four for bilinear, one for read and nearest), the drain state
// accumulates the last product and the final state loads the result register. A read
// outside the image skips the fetch and goes straight to the final state; a write
// writes the memory in the axis state and returns to idle. The single memory port
// serializes every access.
// A result waits in its output register while the receiver stalls, and the next request
// is taken meanwhile; only a second finished result stalls the block until the first
// has been taken.
// Reset clears the control state and restores the register defaults.
module wrapped_bilinear_texture_sampler #(
	parameter int MAX_WIDTH       = wbts_pkg::MaxWidthDef,
	parameter int MAX_HEIGHT      = wbts_pkg::MaxHeightDef,
	parameter int MAX_CHANNELS    = wbts_pkg::MaxChannelsDef,
	parameter int COORD_FRAC_BITS = wbts_pkg::CoordFracBitsDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	wbts_req_if.sink                    req,
	wbts_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wbts_pkg::PaddrW-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import wbts_pkg::*;

	localparam int F      = COORD_FRAC_BITS;
	localparam int WW     = F + 1;
	localparam int PW     = 2 * WW;
	localparam int AccW   = 2 * F + 9;
	localparam int Depth  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int DW     = 8 * MAX_CHANNELS;
	localparam logic [WW-1:0] One = WW'(1) << F;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_AXIS  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	// Configuration registers, held already clamped.
	logic [ExtentW-1:0] width_q, height_q;
	logic [CountW-1:0]  count_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= clamp_reg(ExtentW'(256), MAX_WIDTH);
			height_q <= clamp_reg(ExtentW'(256), MAX_HEIGHT);
			count_q  <= CountW'(clamp_reg(ExtentW'(4), MAX_CHANNELS));
		end else if (cfg_wr) begin
			case (paddr[3:2])
				RegWidth:  width_q  <= clamp_reg(pwdata[ExtentW-1:0], MAX_WIDTH);
				RegHeight: height_q <= clamp_reg(pwdata[ExtentW-1:0], MAX_HEIGHT);
				RegCount:  count_q  <= CountW'(clamp_reg({6'd0, pwdata[CountW-1:0]},
					MAX_CHANNELS));
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			RegWidth:  prdata = 32'(width_q);
			RegHeight: prdata = 32'(height_q);
			RegCount:  prdata = 32'(count_q);
			default:   prdata = '0;
		endcase
	end

	// Captured request.
	logic [1:0]  func_q;
	logic [7:0]  pos_x_q, pos_y_q;
	logic [31:0] wpix_q;
	logic [15:0] u_q, v_q;

	logic [2:0] state_q;
	logic       in_acc;
	assign req.ready = (state_q == S_IDLE);
	assign in_acc    = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= req.func;
			pos_x_q <= req.pos_x;
			pos_y_q <= req.pos_y;
			wpix_q  <= {req.write_ch3, req.write_ch2, req.write_ch1, req.write_ch0};
			u_q     <= req.coord_u;
			v_q     <= req.coord_v;
		end
	end

	// Index and weight computation for both axes; only the low F bits repeat.
	logic [F-1:0]       u_frac, v_frac;
	logic [ExtentW-1:0] ax0, ax1, ay0, ay1;
	logic [WW-1:0]      awx0, awy0;
	assign u_frac = F'({24'd0, u_q});
	assign v_frac = F'({24'd0, v_q});

	wbts_axis #(.FRAC(F)) u_axis (.coord(u_frac), .extent(width_q),
		.idx0(ax0), .idx1(ax1), .w0(awx0));
	wbts_axis #(.FRAC(F)) v_axis (.coord(v_frac), .extent(height_q),
		.idx0(ay0), .idx1(ay1), .w0(awy0));

	logic [ExtentW-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [WW-1:0]      wx0_q, wy0_q;
	logic [1:0]         k_q, last_q;
	logic               err_q;
	logic               in_image;
	assign in_image = (9'(pos_x_q) < width_q) && (9'(pos_y_q) < height_q);

	// Texel memory port.
	logic          ram_en, ram_we;
	logic [AW-1:0] ram_addr;
	logic [DW-1:0] ram_rdata;
	logic [ExtentW-1:0] fx, fy;
	logic [WW-1:0]      fwx, fwy;
	logic [31:0]        wmask;

	always_comb begin
		case (k_q)
			2'd0:    begin fx = x0_q; fy = y0_q; fwx = wx0_q;       fwy = wy0_q;       end
			2'd1:    begin fx = x0_q; fy = y1_q; fwx = wx0_q;       fwy = One - wy0_q; end
			2'd2:    begin fx = x1_q; fy = y0_q; fwx = One - wx0_q; fwy = wy0_q;       end
			default: begin fx = x1_q; fy = y1_q; fwx = One - wx0_q; fwy = One - wy0_q; end
		endcase
	end

	assign wmask  = wpix_q & chan_mask(count_q);
	assign ram_we = (state_q == S_AXIS) && (func_q == FuncWrite) && in_image;
	assign ram_en = ram_we || (state_q == S_FETCH);
	always_comb begin
		if (state_q == S_AXIS) begin
			ram_addr = AW'(32'(pos_y_q) * MAX_WIDTH + 32'(pos_x_q));
		end else begin
			ram_addr = AW'(32'(fy) * MAX_WIDTH + 32'(fx));
		end
	end

	wbts_ram #(.WIDTH(DW), .DEPTH(Depth)) texel_ram (
		.clk(clk), .en(ram_en), .we(ram_we), .addr(ram_addr),
		.wdata(wmask[DW-1:0]), .rdata(ram_rdata));

	// Weight of the texel in flight, aligned with the memory read data.
	logic          pend_s1;
	logic [PW-1:0] wgt_s1;
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) begin
			wgt_s1 <= PW'(fwx) * PW'(fwy);
		end
	end

	// Accumulate the weighted channels of each fetched texel. The product is formed at
	// the accumulator width, since a full channel times unit weight needs 40 bits.
	logic [31:0]     texel;
	logic [AccW-1:0] acc_q [4];
	assign texel = 32'(ram_rdata) & chan_mask(count_q);

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			if (state_q == S_AXIS) begin
				acc_q[c] <= '0;
			end else if (pend_s1) begin
				acc_q[c] <= acc_q[c] + AccW'(texel[8*c +: 8]) * AccW'(wgt_s1);
			end
		end
	end

	// Control sequencer.
	logic out_valid_q;
	logic out_load;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_s1 <= 1'b0;
			k_q     <= '0;
		end else begin
			pend_s1 <= (state_q == S_FETCH);
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					k_q <= '0;
					if (func_q == FuncWrite) begin
						state_q <= S_IDLE;
					end else if (func_q == FuncRead && !in_image) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					k_q <= k_q + 2'd1;
					if (k_q == last_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Read and nearest use the main texel alone with unit weight on both axes.
	always_ff @(posedge clk) begin
		if (state_q == S_AXIS) begin
			err_q <= (func_q == FuncRead) && !in_image;
			if (func_q == FuncBilinear) begin
				x0_q <= ax0; x1_q <= ax1; y0_q <= ay0; y1_q <= ay1;
				wx0_q <= awx0; wy0_q <= awy0; last_q <= 2'd3;
			end else begin
				if (func_q == FuncRead) begin
					x0_q <= 9'(pos_x_q); y0_q <= 9'(pos_y_q);
				end else begin
					x0_q <= ax0; y0_q <= ay0;
				end
				x1_q <= ax1; y1_q <= ay1;
				wx0_q <= One; wy0_q <= One; last_q <= 2'd0;
			end
		end
	end

	// Result register.
	logic [7:0] res [4];
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (err_q) begin
				res[c] = '0;
			end else if (acc_q[c][AccW-1:2*F] > 9'd255) begin
				res[c] = 8'hFF;
			end else begin
				res[c] = acc_q[c][2*F +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.out_ch0     <= res[0];
			rsp.out_ch1     <= res[1];
			rsp.out_ch2     <= res[2];
			rsp.out_ch3     <= res[3];
			rsp.range_error <= err_q;
		end
	end
	assign rsp.valid = out_valid_q;

	// A fetched texel arrives only the cycle after a fetch was issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q == S_FETCH))
		else $error("texel data without a fetch");

	// A finished result never overwrites one the receiver has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !rsp.ready) |=> (state_q == S_FIN))
		else $error("result register overrun");

	// The fetch counter stays within the neighborhood of the request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> (k_q <= last_q))
		else $error("fetch counter out of range");
endmodule

// File: rtl/core/wbts_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module wbts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                          wdata,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end
endmodule

// File: rtl/core/wbts_axis.sv
// Splits a repeating fractional coordinate into main texel, neighbor texel and main weight.
// Depends on wbts_pkg for the extent width.
module wbts_axis #(
	parameter int FRAC = 16
) (
	input  logic [FRAC-1:0]             coord,
	input  logic [wbts_pkg::ExtentW-1:0] extent,
	output logic [wbts_pkg::ExtentW-1:0] idx0,
	output logic [wbts_pkg::ExtentW-1:0] idx1,
	output logic [FRAC:0]                w0
);
	import wbts_pkg::*;

	localparam logic [FRAC:0] One  = (FRAC+1)'(1) << FRAC;
	localparam logic [FRAC:0] Half = (FRAC+1)'(1) << (FRAC - 1);

	logic [FRAC+ExtentW-1:0] prod;
	logic [ExtentW-1:0]      pos;
	logic [ExtentW-1:0]      last;
	logic [FRAC-1:0]         frac;

	always_comb begin
		prod = (FRAC+ExtentW)'(coord) * (FRAC+ExtentW)'(extent);
		pos  = prod[FRAC+ExtentW-1:FRAC];
		frac = prod[FRAC-1:0];
		last = extent - ExtentW'(1);
		idx0 = (pos >= extent) ? last : pos;
		// The neighbor lies on the side of the texel center that the position falls on.
		if ({1'b0, frac} < Half) begin
			idx1 = (idx0 == '0) ? last : idx0 - ExtentW'(1);
			w0   = {1'b0, frac} + Half;
		end else begin
			idx1 = (idx0 == last) ? '0 : idx0 + ExtentW'(1);
			w0   = One - {1'b0, frac} + Half;
		end
	end
endmodule

// File: dv/wbts_checker.sv
// Checker of the texture sampler: watches the request, result and register channels.
// Depends on wbts_pkg and the wbts_req_if/wbts_rsp_if interfaces of the block.
module wbts_checker (
	input  logic        clk,
	input  logic        arst_n,
	wbts_req_if         req,
	wbts_rsp_if         rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [wbts_pkg::PaddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import wbts_pkg::*;

	typedef struct {
		logic [7:0] ch[4];
		logic       range_error;
	} color_t;

	logic [31:0] texels [0:65535];
	int unsigned img_w, img_h, n_chan;
	color_t expected_colors[$];

	initial begin
		foreach (texels[i]) texels[i] = '0;
		fail_count = 0;
		pending_count = 0;
	end

	function automatic int unsigned fit_extent(int unsigned v, int unsigned maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic logic [31:0] live_mask();
		return (n_chan >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n_chan)) - 1);
	endfunction

	function automatic logic [31:0] texel_at(int unsigned x, int unsigned y);
		return texels[y * 256 + x] & live_mask();
	endfunction

	// Main index, neighbour index and main weight (Q1.16) along one axis.
	function automatic void split_axis(input logic [15:0] c, input int unsigned n,
		output int unsigned i0, output int unsigned i1, output longint unsigned w0);
		longint unsigned t, p;
		t = longint'(c) * n;
		i0 = int'(t >> 16);
		p = t & 64'hFFFF;
		if (i0 >= n) i0 = n - 1;
		if (p < 64'd32768) begin
			i1 = (i0 == 0) ? n - 1 : i0 - 1;
			w0 = p + 64'd32768;
		end else begin
			i1 = (i0 == n - 1) ? 0 : i0 + 1;
			w0 = 64'd65536 - p + 64'd32768;
		end
	endfunction

	function automatic color_t predict_color();
		color_t r;
		int unsigned x0, x1, y0, y1;
		longint unsigned wx0, wy0, wx1, wy1, acc;
		logic [31:0] px, p00, p01, p10, p11;
		r.range_error = 1'b0;
		px = '0;
		if (req.func == FuncRead) begin
			if (req.pos_x >= img_w || req.pos_y >= img_h) r.range_error = 1'b1;
			else px = texel_at(req.pos_x, req.pos_y);
		end else begin
			split_axis(req.coord_u, img_w, x0, x1, wx0);
			split_axis(req.coord_v, img_h, y0, y1, wy0);
			if (req.func == FuncNearest) begin
				px = texel_at(x0, y0);
			end else begin
				wx1 = 64'd65536 - wx0;
				wy1 = 64'd65536 - wy0;
				p00 = texel_at(x0, y0);
				p01 = texel_at(x0, y1);
				p10 = texel_at(x1, y0);
				p11 = texel_at(x1, y1);
				for (int c = 0; c < 4; c++) begin
					acc = longint'(p00[8*c +: 8]) * wx0 * wy0
						+ longint'(p01[8*c +: 8]) * wx0 * wy1
						+ longint'(p10[8*c +: 8]) * wx1 * wy0
						+ longint'(p11[8*c +: 8]) * wx1 * wy1;
					acc = acc >> 32;
					px[8*c +: 8] = (acc > 255) ? 8'hFF : acc[7:0];
				end
			end
		end
		px &= live_mask();
		for (int c = 0; c < 4; c++) r.ch[c] = px[8*c +: 8];
		return r;
	endfunction

	// Four-state compare, so that an unknown value on the block's output counts as wrong.
	task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		color_t e;
		logic [31:0] px;
		if (!arst_n) begin
			img_w = 256;
			img_h = 256;
			n_chan = 4;
			expected_colors.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_colors.size() == 0) begin
					$error("result arrived with no request outstanding");
					fail_count++;
				end else begin
					e = expected_colors.pop_front();
					check_field("out_ch0", e.ch[0], rsp.out_ch0);
					check_field("out_ch1", e.ch[1], rsp.out_ch1);
					check_field("out_ch2", e.ch[2], rsp.out_ch2);
					check_field("out_ch3", e.ch[3], rsp.out_ch3);
					check_field("range_error", 8'(e.range_error), 8'(rsp.range_error));
				end
			end
			if (req.valid && req.ready) begin
				if (req.func == FuncWrite) begin
					if (req.pos_x < img_w && req.pos_y < img_h) begin
						px = {req.write_ch3, req.write_ch2, req.write_ch1, req.write_ch0};
						texels[req.pos_y * 256 + req.pos_x] = px & live_mask();
					end
				end else begin
					expected_colors.insert(expected_colors.size(), predict_color());
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					RegWidth:  img_w = fit_extent(pwdata[8:0], MaxWidthDef);
					RegHeight: img_h = fit_extent(pwdata[8:0], MaxHeightDef);
					RegCount:  n_chan = fit_extent(pwdata[2:0], MaxChannelsDef);
					default: ;
				endcase
			end
		end
		pending_count = expected_colors.size();
	end
endmodule

// File: dv/tb_wrapped_bilinear_texture_sampler.sv
// Top of the texture sampler testbench: clock, reset, stimulus, receiver and verdict.
// Depends on wbts_pkg, the block's interfaces, the block and wbts_checker.
module tb_wrapped_bilinear_texture_sampler;
	timeunit 1ns;
	timeprecision 1ps;
	import wbts_pkg::*;

	// About 630 requests, slowed by receiver stalls and one long receiver hold-off, set
	// this limit, which a correct run stays well inside.
	localparam int CycleLimit = 200_000;

	// Image settings of the random phases. Every extent stays inside the written
	// 8x8 corner or, for a width above the limit, inside the fully written row 0.
	localparam int PhaseW[7] = '{1, 3, 0, 511, 8, 5, 8};
	localparam int PhaseH[7] = '{1, 5, 7, 1, 8, 0, 8};
	localparam int PhaseN[7] = '{1, 2, 3, 0, 7, 4, 6};

	typedef struct {
		logic [1:0]  func;
		logic [7:0]  x, y;
		logic [7:0]  ch[4];
		logic [15:0] u, v;
	} sampler_req_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PaddrW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	int fail_count, pending_count;
	int cycle_count;
	int burst_left;
	logic hold_go;
	// The testbench's own view of the active extent, used only to aim coordinates.
	int cur_w, cur_h;

	wbts_req_if req_ch();
	wbts_rsp_if rsp_ch();

	wrapped_bilinear_texture_sampler dut (
		.clk, .arst_n, .req(req_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	wbts_checker checker_i (
		.clk, .arst_n, .req(req_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending_count
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The timeout watchdog counts every cycle from the start of the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The result receiver switches between stall patterns, each held for a random span.
	// A long hold-off asked for by the stimulus side is counted down here, so the
	// sampler fills its output register and must push back on new requests.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		bit hold_taken;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 250);
			end
			mode_left--;
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
					default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// One APB write: setup cycle, then access cycle; pready is always high.
	// An idle cycle follows, so that back-to-back writes never assign twice at one edge.
	task automatic write_register(logic [1:0] index, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Requests go out in bursts. Valid is only lowered when a gap starts, so it is
	// never dropped and raised again within the same time step.
	task automatic send_request(sampler_req_t r);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= r.func;
		req_ch.pos_x <= r.x;
		req_ch.pos_y <= r.y;
		req_ch.write_ch0 <= r.ch[0];
		req_ch.write_ch1 <= r.ch[1];
		req_ch.write_ch2 <= r.ch[2];
		req_ch.write_ch3 <= r.ch[3];
		req_ch.coord_u <= r.u;
		req_ch.coord_v <= r.v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	function automatic sampler_req_t make_request(logic [1:0] func, int x, int y,
		int u, int v);
		sampler_req_t r;
		r.func = func;
		r.x = x[7:0];
		r.y = y[7:0];
		foreach (r.ch[c]) r.ch[c] = 8'($urandom_range(0, 255));
		r.u = u[15:0];
		r.v = v[15:0];
		return r;
	endfunction

	// Coordinates favor the active image, and sometimes land anywhere so that the
	// out-of-image write and read cases are exercised.
	function automatic int pick_pos(int extent);
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, extent - 1)
			: $urandom_range(0, 255);
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 16'hFFFF;
			2: return 16'h8000 + $urandom_range(0, 2) - 1;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	function automatic int fit_value(int v, int maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	// The block may still be finishing a write when the last result has arrived,
	// so a further wait follows before any register changes.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_count != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_image(int w, int h, int n);
		drain_results();
		write_register(RegWidth, w);
		write_register(RegHeight, h);
		write_register(RegCount, n);
		cur_w = fit_value(w, 256);
		cur_h = fit_value(h, 256);
	endtask

	task automatic run_random(int count);
		sampler_req_t r;
		repeat (count) begin
			r = make_request(2'($urandom_range(0, 3)), pick_pos(cur_w), pick_pos(cur_h),
				pick_coord(), pick_coord());
			send_request(r);
		end
	endtask

	initial begin
		sampler_req_t r;

		burst_left = 0;
		hold_go = 1'b0;
		cur_w = 256;
		cur_h = 256;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FuncWrite;
		req_ch.pos_x <= '0;
		req_ch.pos_y <= '0;
		req_ch.write_ch0 <= '0;
		req_ch.write_ch1 <= '0;
		req_ch.write_ch2 <= '0;
		req_ch.write_ch3 <= '0;
		req_ch.coord_u <= '0;
		req_ch.coord_v <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The store is undefined until written. Row 0 is filled across the full width
		// and the 8x8 corner is completed; every later image stays inside that area.
		for (int x = 0; x < 256; x++) begin
			send_request(make_request(FuncWrite, x, 0, 0, 0));
		end
		for (int y = 1; y < 8; y++) begin
			for (int x = 0; x < 8; x++) begin
				send_request(make_request(FuncWrite, x, y, 0, 0));
			end
		end

		// Directed part on the 8x8 corner: field extremes and every function.
		set_image(8, 8, 4);
		r = make_request(FuncWrite, 0, 0, 0, 0);
		r.ch = '{8'h00, 8'h00, 8'h00, 8'h00};
		send_request(r);
		r = make_request(FuncWrite, 7, 7, 0, 0);
		r.ch = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_request(r);
		send_request(make_request(FuncRead, 0, 0, 0, 0));
		send_request(make_request(FuncRead, 7, 7, 0, 0));
		send_request(make_request(FuncRead, 255, 255, 0, 0));
		send_request(make_request(FuncNearest, 0, 0, 0, 0));
		send_request(make_request(FuncNearest, 0, 0, 16'hFFFF, 16'hFFFF));
		send_request(make_request(FuncBilinear, 0, 0, 0, 0));
		send_request(make_request(FuncBilinear, 0, 0, 16'hFFFF, 16'hFFFF));
		send_request(make_request(FuncBilinear, 0, 0, 16'h8000, 16'h7FFF));
		send_request(make_request(FuncBilinear, 0, 0, 16'h0080, 16'hFF80));

		// A long receiver hold-off while requests keep coming, so the block stalls.
		hold_go = 1'b1;
		run_random(60);

		// Register settings include zero and values above the limits, which the
		// block takes as one and as the maximum respectively.
		foreach (PhaseW[i]) begin
			set_image(PhaseW[i], PhaseH[i], PhaseN[i]);
			run_random(35);
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// File: wrapped_bilinear_texture_sampler.f
rtl/core/wbts_pkg.sv
rtl/core/wbts_if.sv
rtl/core/wbts_ram.sv
rtl/core/wbts_axis.sv
rtl/core/wrapped_bilinear_texture_sampler.sv
dv/wbts_checker.sv
dv/tb_wrapped_bilinear_texture_sampler.sv
